@@ sv/pcek7_pkg.sv @@
// ----------------------------------------------------------------------------
// pcek7_pkg
// Types and constants shared by the punctured K=7 convolutional encoder.
// ----------------------------------------------------------------------------
package pcek7_pkg;

   // Longest puncturing pattern, in symbol pairs
   localparam int unsigned MAX_PERIOD  = 8;
   // Information bits (and so symbol pairs) per input beat
   localparam int unsigned PAIRS       = 8;
   // Entries in the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [6:0] POLY_FIRST_RESET  = 7'd121;
   localparam logic [6:0] POLY_SECOND_RESET = 7'd91;
   localparam logic [3:0] PERIOD_RESET      = 4'd1;
   localparam logic [7:0] KEEP_FIRST_RESET  = 8'd1;
   localparam logic [7:0] KEEP_SECOND_RESET = 8'd1;

   typedef enum logic [2:0] {
      CSR_POLY_FIRST   = 3'd0,
      CSR_POLY_SECOND  = 3'd1,
      CSR_PUNCT_PERIOD = 3'd2,
      CSR_KEEP_FIRST   = 3'd3,
      CSR_KEEP_SECOND  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [6:0] poly_first;
      logic [6:0] poly_second;
      logic [3:0] punct_period;
      logic [7:0] keep_first;
      logic [7:0] keep_second;
   } cfg_type;

   // One encoded byte: parity bits and keep flags, pair 0 transmitted first
   typedef struct packed {
      logic [PAIRS-1:0] g_first;
      logic [PAIRS-1:0] g_second;
      logic [PAIRS-1:0] keep_first;
      logic [PAIRS-1:0] keep_second;
   } pair_word_type;

endpackage

@@ sv/punctured_conv_encoder_k7.sv @@
// ----------------------------------------------------------------------------
// punctured_conv_encoder_k7
// Rate-1/2, K=7 convolutional encoder with a programmable puncturer.
// ----------------------------------------------------------------------------
// One data byte per beat, MSB encoded first, gives one result beat holding the
// kept coded bits right-aligned (first bit highest, unused bits zero) and
// their count. The block takes a byte every clock cycle while req_tready is
// high; the front stage is combinational, and each encoded byte is registered
// in the two-entry queue and then in the output register. The encoder state
// and the puncture phase advance at request time, so bytes may follow each
// other without gaps. Write the configuration registers (index 0 first
// generator, 1 second generator, 2 period, 3 first keep mask, 4 second keep
// mask) only while no byte is in flight; csr_ready is always high.
module punctured_conv_encoder_k7 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] coded_bits, [20:16] bit_count, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   pcek7_pkg::cfg_type       cfg_ff;
   pcek7_pkg::pair_word_type push_word;
   pcek7_pkg::pair_word_type pop_word;
   logic                     queue_ready;
   logic                     push;
   logic                     pop;
   logic                     pop_valid;
   logic [15:0]              coded_bits;
   logic [4:0]               bit_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poly_first   <= pcek7_pkg::POLY_FIRST_RESET;
         cfg_ff.poly_second  <= pcek7_pkg::POLY_SECOND_RESET;
         cfg_ff.punct_period <= pcek7_pkg::PERIOD_RESET;
         cfg_ff.keep_first   <= pcek7_pkg::KEEP_FIRST_RESET;
         cfg_ff.keep_second  <= pcek7_pkg::KEEP_SECOND_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pcek7_pkg::CSR_POLY_FIRST:   cfg_ff.poly_first   <= csr_data[6:0];
            pcek7_pkg::CSR_POLY_SECOND:  cfg_ff.poly_second  <= csr_data[6:0];
            pcek7_pkg::CSR_PUNCT_PERIOD: cfg_ff.punct_period <= csr_data[3:0];
            pcek7_pkg::CSR_KEEP_FIRST:   cfg_ff.keep_first   <= csr_data;
            pcek7_pkg::CSR_KEEP_SECOND:  cfg_ff.keep_second  <= csr_data;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   pcek7_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .data_byte   (req_tdata),
      .queue_ready (queue_ready),
      .push        (push),
      .push_word   (push_word)
   );

   pcek7_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word)
   );

   pcek7_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .coded_bits (coded_bits),
      .bit_count  (bit_count)
   );

   assign rsp_tdata = {3'b000, bit_count, coded_bits};

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (bit_count <= 5'd16))
      else $error("bit count above sixteen");

   a_idle_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat straight after reset");

endmodule

@@ sv/pcek7_front.sv @@
// ----------------------------------------------------------------------------
// pcek7_front
// Accepts data bytes, runs the K=7 encoder over all eight bits and marks
// which parity bits the puncturing pattern keeps.
// ----------------------------------------------------------------------------
module pcek7_front (
   input  logic                    clock,
   input  logic                    reset,
   input  pcek7_pkg::cfg_type      cfg,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              data_byte,
   input  logic                    queue_ready,
   output logic                    push,
   output pcek7_pkg::pair_word_type push_word
);

   logic [5:0]  state_ff;
   logic [5:0]  state_in;
   logic [2:0]  phase_ff;
   logic [2:0]  phase_in;
   logic [13:0] window;
   logic [6:0]  shift_reg;
   logic [3:0]  period_eff;
   logic [3:0]  phase_cur;
   logic [3:0]  phase_nxt;

   assign req_ready = queue_ready;
   assign push      = req_valid & queue_ready;

   // Oldest bit lowest: stored state, then the byte MSB first
   always_comb begin
      window[5:0] = state_ff;
      for (int i = 0; i < int'(pcek7_pkg::PAIRS); i++) begin
         window[6+i] = data_byte[7-i];
      end
   end

   always_comb begin
      if (cfg.punct_period == 4'd0) begin
         period_eff = 4'd1;
      end else if (cfg.punct_period > 4'(pcek7_pkg::MAX_PERIOD)) begin
         period_eff = 4'(pcek7_pkg::MAX_PERIOD);
      end else begin
         period_eff = cfg.punct_period;
      end
   end

   // Parity per pair; walk the phase across the eight pairs and wrap once it
   // reaches the period
   always_comb begin
      push_word.g_first     = '0;
      push_word.g_second    = '0;
      push_word.keep_first  = '0;
      push_word.keep_second = '0;
      shift_reg             = '0;
      phase_cur             = {1'b0, phase_ff};
      phase_nxt             = '0;
      for (int k = 0; k < int'(pcek7_pkg::PAIRS); k++) begin
         shift_reg                = window[k +: 7];
         push_word.g_first[k]     = ^(shift_reg & cfg.poly_first);
         push_word.g_second[k]    = ^(shift_reg & cfg.poly_second);
         push_word.keep_first[k]  = cfg.keep_first[phase_cur[2:0]];
         push_word.keep_second[k] = cfg.keep_second[phase_cur[2:0]];
         phase_nxt                = phase_cur + 4'd1;
         phase_cur                = (phase_nxt >= period_eff) ? 4'd0 : phase_nxt;
      end
   end

   assign state_in = push ? window[13:8] : state_ff;
   assign phase_in = push ? phase_cur[2:0] : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

@@ sv/pcek7_fifo.sv @@
// ----------------------------------------------------------------------------
// pcek7_fifo
// Short queue of encoded bytes between the front and the back.
// ----------------------------------------------------------------------------
module pcek7_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pcek7_pkg::pair_word_type push_word,
   output logic                     push_ready,
   input  logic                     pop,
   output logic                     pop_valid,
   output pcek7_pkg::pair_word_type pop_word
);

   localparam int unsigned PTR_W = (pcek7_pkg::QUEUE_DEPTH > 1) ?
                                   $clog2(pcek7_pkg::QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(pcek7_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pcek7_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(pcek7_pkg::QUEUE_DEPTH);

   pcek7_pkg::pair_word_type mem [pcek7_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign push_ready = (count_ff != DEPTH_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue fill count beyond depth");

   a_pop_drains : assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop after a pop");

endmodule

@@ sv/pcek7_back.sv @@
// ----------------------------------------------------------------------------
// pcek7_back
// Packs the kept parity bits of one byte right-aligned, first bit highest,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module pcek7_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   input  pcek7_pkg::pair_word_type pop_word,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [15:0]              coded_bits,
   output logic [4:0]               bit_count
);

   logic        valid_ff;
   logic        valid_in;
   logic [15:0] coded_ff;
   logic [15:0] coded_in;
   logic [4:0]  count_ff;
   logic [4:0]  count_in;
   logic        load;

   assign load     = !valid_ff || rsp_ready;
   assign pop      = pop_valid && load;
   assign valid_in = pop_valid || (valid_ff && !rsp_ready);

   // Append zero, one or two bits per pair
   always_comb begin
      coded_in = '0;
      count_in = '0;
      for (int k = 0; k < int'(pcek7_pkg::PAIRS); k++) begin
         case ({pop_word.keep_first[k], pop_word.keep_second[k]})
            2'b11: begin
               coded_in = {coded_in[13:0], pop_word.g_first[k], pop_word.g_second[k]};
               count_in = count_in + 5'd2;
            end
            2'b10: begin
               coded_in = {coded_in[14:0], pop_word.g_first[k]};
               count_in = count_in + 5'd1;
            end
            2'b01: begin
               coded_in = {coded_in[14:0], pop_word.g_second[k]};
               count_in = count_in + 5'd1;
            end
            default: begin
               coded_in = coded_in;
               count_in = count_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         coded_ff <= coded_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign coded_bits = coded_ff;
   assign bit_count  = count_ff;

endmodule
